### sv/polyline_joint_bisector_normal_assert.svh
// Assertion macros for the polyline joint bisector normal block.
// Needs clk and arst_n in the scope that expands them.
`ifndef POLYLINE_JOINT_BISECTOR_NORMAL_ASSERT_SVH
`define POLYLINE_JOINT_BISECTOR_NORMAL_ASSERT_SVH

// consequent in the same cycle
`define PJBN_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent in the next cycle
`define PJBN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/pjbn_pkg.sv
// Shared types and constants of the polyline joint bisector normal block.
// No dependencies.
`timescale 1ns / 1ps

package pjbn_pkg;

	localparam int IN_W      = 36;
	localparam int DIFF_W    = IN_W + 1;
	localparam int Q_W       = 16;
	localparam int MAG_W     = 30;
	localparam int SQ_W      = 2 * MAG_W + 2;
	localparam int ROOT_W    = MAG_W + 1;
	localparam int DIV_SHIFT = 15;
	localparam int DIV_STEPS = DIV_SHIFT + 1;
	localparam int DIV_W     = MAG_W + DIV_SHIFT + 1;
	localparam int PROD_W    = 2 * Q_W;
	localparam int SUM_W     = Q_W + 1;
	localparam int DOT_W     = PROD_W + 2;
	localparam int RPROD_W   = PROD_W + SUM_W;
	localparam int R_W       = RPROD_W + 1;
	localparam int FRAC_W    = 14;

	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam logic [ADDR_W-3:0] REG_COS_THRESHOLD = '0;
	localparam logic signed [Q_W-1:0] COS_RESET = 16'sd14090;

	typedef struct packed {
		logic vld;
		logic zero;
	} unit_stat_t;

endpackage

### sv/pjbn_unit.sv
// Pipelined Q2.14 unit-vector normalizer: scale, sum of squares,
// bit-per-stage square root and bit-per-stage division. Uses pjbn_pkg.
`timescale 1ns / 1ps

module pjbn_unit import pjbn_pkg::*; #(
	parameter int W  = DIFF_W,
	parameter int SW = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [2:0][W-1:0]      vec,
	input  logic [SW-1:0]          side_in,
	output unit_stat_t             stat,
	output logic [2:0][Q_W-1:0]    uvec,
	output logic [SW-1:0]          side_out
);

	localparam int PW = $clog2(W);
	localparam int NS = ROOT_W;
	localparam int DS = DIV_STEPS;

	typedef struct packed {
		logic [2:0][MAG_W-1:0] m;
		logic [2:0]            neg;
		logic                  zero;
		logic [SW-1:0]         side;
	} carry_t;

	logic [2:0][W-1:0]       mag_s1, mag_s2;
	logic [2:0]              neg_s1, neg_s2, neg_s3;
	logic [SW-1:0]           side_s1, side_s2, side_s3;
	logic                    v_s1, v_s2, v_s3, v_s4;
	logic [PW-1:0]           pos_s2;
	logic                    zero_s2, zero_s3;
	logic [2:0][MAG_W-1:0]   m_s3;
	logic [2:0][2*MAG_W-1:0] sq_s4;
	carry_t                  c_s4;

	logic [SQ_W-1:0]         sq_rem_s  [NS+1];
	logic [ROOT_W-1:0]       sq_root_s [NS+1];
	carry_t                  sq_c_s    [NS+1];
	logic [NS:0]             sq_v_s;

	logic [2:0][DIV_W-1:0]   dv_rem_s [1:DS];
	logic [ROOT_W-1:0]       dv_len_s [1:DS];
	logic [2:0][Q_W-1:0]     dv_q_s   [1:DS];
	carry_t                  dv_c_s   [1:DS];
	logic [DS:1]             dv_v_s;

	logic [2:0][Q_W-1:0]     u_s6;
	logic                    zero_s6, v_s6;
	logic [SW-1:0]           side_s6;

	logic [W-1:0]            orv;
	logic [PW-1:0]           pos_nx;
	logic [2:0][MAG_W-1:0]   m_nx;
	logic [SQ_W-1:0]         nx_rem  [1:NS];
	logic [ROOT_W-1:0]       nx_root [1:NS];
	logic [2:0][DIV_W-1:0]   pr_rem [1:DS];
	logic [ROOT_W-1:0]       pr_len [1:DS];
	logic [2:0][Q_W-1:0]     pr_q   [1:DS];
	logic [2:0][DIV_W-1:0]   dn_rem [1:DS];
	logic [2:0][Q_W-1:0]     dn_q   [1:DS];
	logic [2:0][Q_W-1:0]     u_nx;

	always_comb begin
		orv = mag_s1[0] | mag_s1[1] | mag_s1[2];
		pos_nx = '0;
		for (int b = 0; b < W; b++) begin
			if (orv[b]) pos_nx = PW'(b);
		end
	end

	always_comb begin
		logic [W-1:0] sh;
		for (int i = 0; i < 3; i++) begin
			if (pos_s2 >= PW'(MAG_W - 1)) begin
				sh = mag_s2[i] >> (pos_s2 - PW'(MAG_W - 1));
			end else begin
				sh = mag_s2[i] << (PW'(MAG_W - 1) - pos_s2);
			end
			m_nx[i] = sh[MAG_W-1:0];
		end
	end

	always_comb begin
		logic [SQ_W-1:0] t;
		int k;
		for (int j = 1; j <= NS; j++) begin
			k = NS - j;
			t = (SQ_W'(sq_root_s[j-1]) << (k + 1)) + (SQ_W'(1) << (2 * k));
			if (sq_rem_s[j-1] >= t) begin
				nx_rem[j]  = sq_rem_s[j-1] - t;
				nx_root[j] = sq_root_s[j-1] | (ROOT_W'(1) << k);
			end else begin
				nx_rem[j]  = sq_rem_s[j-1];
				nx_root[j] = sq_root_s[j-1];
			end
		end
	end

	always_comb begin
		logic [DIV_W-1:0] d;
		int k;
		for (int i = 0; i < 3; i++) begin
			pr_rem[1][i] = DIV_W'(sq_c_s[NS].m[i]) << DIV_SHIFT;
		end
		pr_len[1] = sq_root_s[NS];
		pr_q[1]   = '0;
		for (int j = 2; j <= DS; j++) begin
			pr_rem[j] = dv_rem_s[j-1];
			pr_len[j] = dv_len_s[j-1];
			pr_q[j]   = dv_q_s[j-1];
		end
		for (int j = 1; j <= DS; j++) begin
			k = DS - j;
			d = DIV_W'(pr_len[j]) << k;
			for (int i = 0; i < 3; i++) begin
				if (pr_rem[j][i] >= d) begin
					dn_rem[j][i] = pr_rem[j][i] - d;
					dn_q[j][i]   = pr_q[j][i] | (Q_W'(1) << k);
				end else begin
					dn_rem[j][i] = pr_rem[j][i];
					dn_q[j][i]   = pr_q[j][i];
				end
			end
		end
	end

	always_comb begin
		logic [Q_W:0] rq;
		logic [Q_W-1:0] qr;
		for (int i = 0; i < 3; i++) begin
			rq = {1'b0, dv_q_s[DS][i]} + (Q_W+1)'(1);
			qr = rq[Q_W:1];
			if (dv_c_s[DS].zero) begin
				u_nx[i] = '0;
			end else if (dv_c_s[DS].neg[i]) begin
				u_nx[i] = -qr;
			end else begin
				u_nx[i] = qr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			sq_v_s <= '0;
			dv_v_s <= '0;
			v_s6   <= 1'b0;
		end else if (en) begin
			v_s1   <= in_vld;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			sq_v_s <= {sq_v_s[NS-1:0], v_s4};
			dv_v_s <= {dv_v_s[DS-1:1], sq_v_s[NS]};
			v_s6   <= dv_v_s[DS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][W-1];
				mag_s1[i] <= vec[i][W-1] ? -vec[i] : vec[i];
				sq_s4[i]  <= (2*MAG_W)'(m_s3[i]) * (2*MAG_W)'(m_s3[i]);
			end
			side_s1 <= side_in;
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			side_s2 <= side_s1;
			pos_s2  <= pos_nx;
			zero_s2 <= (mag_s1[0] | mag_s1[1] | mag_s1[2]) == '0;
			m_s3    <= m_nx;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			side_s3 <= side_s2;
			c_s4    <= '{m: m_s3, neg: neg_s3, zero: zero_s3, side: side_s3};
			sq_rem_s[0]  <= SQ_W'(sq_s4[0]) + SQ_W'(sq_s4[1]) + SQ_W'(sq_s4[2]);
			sq_root_s[0] <= '0;
			sq_c_s[0]    <= c_s4;
			for (int j = 1; j <= NS; j++) begin
				sq_rem_s[j]  <= nx_rem[j];
				sq_root_s[j] <= nx_root[j];
				sq_c_s[j]    <= sq_c_s[j-1];
			end
			dv_c_s[1] <= sq_c_s[NS];
			for (int j = 2; j <= DS; j++) begin
				dv_c_s[j] <= dv_c_s[j-1];
			end
			for (int j = 1; j <= DS; j++) begin
				dv_rem_s[j] <= dn_rem[j];
				dv_len_s[j] <= pr_len[j];
				dv_q_s[j]   <= dn_q[j];
			end
			u_s6    <= u_nx;
			zero_s6 <= dv_c_s[DS].zero;
			side_s6 <= dv_c_s[DS].side;
		end
	end

	assign stat     = '{vld: v_s6, zero: zero_s6};
	assign uvec     = u_s6;
	assign side_out = side_s6;

endmodule

### sv/polyline_joint_bisector_normal.sv
// Bisecting-plane normal at a polyline joint; top level with APB register.
// Order from input word to output word: difference stage, first normalizer pass,
// product stages, second normalizer pass, then select and output stage.
// Throughput: one word per cycle; the whole pipeline holds while an output word waits.
// Reset: arst_n clears all valid bits and loads cos_threshold with 14090.
// Uses pjbn_pkg and pjbn_unit.
`timescale 1ns / 1ps

module polyline_joint_bisector_normal import pjbn_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [IN_W-1:0]   a_x,
	input  logic signed [IN_W-1:0]   a_y,
	input  logic signed [IN_W-1:0]   a_z,
	input  logic signed [IN_W-1:0]   b_x,
	input  logic signed [IN_W-1:0]   b_y,
	input  logic signed [IN_W-1:0]   b_z,
	input  logic signed [IN_W-1:0]   c_x,
	input  logic signed [IN_W-1:0]   c_y,
	input  logic signed [IN_W-1:0]   c_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [Q_W-1:0]    normal_x,
	output logic signed [Q_W-1:0]    normal_y,
	output logic signed [Q_W-1:0]    normal_z,
	output logic                     oriented
);

	localparam int SIDE_W = 3 * Q_W + 2;

	typedef struct packed {
		logic [2:0][Q_W-1:0] alt;
		logic                alt_or;
		logic                use_alt;
	} side_t;

	logic signed [Q_W-1:0]   cos_thr_q;
	logic                    en;

	logic                    v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [2:0][DIFF_W-1:0]  va_s1, vc_s1;

	unit_stat_t              st0, st1, st2;
	logic [2:0][Q_W-1:0]     d0, d1, u2;
	side_t                   side_s3, side_s4, side_s5, side_u;

	logic signed [PROD_W-1:0] pxx_s2, pyy_s2, pzz_s2;
	logic signed [PROD_W-1:0] pyz_s2, pzy_s2, pzx_s2, pxz_s2, pxy_s2, pyx_s2;
	logic [2:0][SUM_W-1:0]    sm_s2, sm_s3;
	logic [2:0][Q_W-1:0]      d0_s2, d1_s2;
	logic                     z0_s2, z1_s2;
	logic [2:0][PROD_W-1:0]   cr_s3;
	logic [5:0][RPROD_W-1:0]  rp_s4;
	logic [2:0][R_W-1:0]      r_s5;

	logic signed [DOT_W-1:0]  dot;
	logic signed [DOT_W-1:0]  thr;
	logic                     too_small;
	side_t                    side_nx;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;
	assign pready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_thr_q <= COS_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_COS_THRESHOLD) begin
			cos_thr_q <= pwdata[Q_W-1:0];
		end
	end

	always_comb begin
		if (paddr[ADDR_W-1:2] == REG_COS_THRESHOLD) begin
			prdata = DATA_W'(cos_thr_q);
		end else begin
			prdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			va_s1[0] <= DIFF_W'(a_x) - DIFF_W'(b_x);
			va_s1[1] <= DIFF_W'(a_y) - DIFF_W'(b_y);
			va_s1[2] <= DIFF_W'(a_z) - DIFF_W'(b_z);
			vc_s1[0] <= DIFF_W'(c_x) - DIFF_W'(b_x);
			vc_s1[1] <= DIFF_W'(c_y) - DIFF_W'(b_y);
			vc_s1[2] <= DIFF_W'(c_z) - DIFF_W'(b_z);
		end
	end

	pjbn_unit #(.W(DIFF_W), .SW(1)) u_norm0 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s1), .vec(va_s1),
		.side_in(1'b0), .stat(st0), .uvec(d0), .side_out()
	);

	pjbn_unit #(.W(DIFF_W), .SW(1)) u_norm1 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s1), .vec(vc_s1),
		.side_in(1'b0), .stat(st1), .uvec(d1), .side_out()
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pxx_s2 <= $signed(d0[0]) * $signed(d1[0]);
			pyy_s2 <= $signed(d0[1]) * $signed(d1[1]);
			pzz_s2 <= $signed(d0[2]) * $signed(d1[2]);
			pyz_s2 <= $signed(d0[1]) * $signed(d1[2]);
			pzy_s2 <= $signed(d0[2]) * $signed(d1[1]);
			pzx_s2 <= $signed(d0[2]) * $signed(d1[0]);
			pxz_s2 <= $signed(d0[0]) * $signed(d1[2]);
			pxy_s2 <= $signed(d0[0]) * $signed(d1[1]);
			pyx_s2 <= $signed(d0[1]) * $signed(d1[0]);
			for (int i = 0; i < 3; i++) begin
				sm_s2[i] <= SUM_W'($signed(d0[i])) + SUM_W'($signed(d1[i]));
			end
			d0_s2 <= d0;
			d1_s2 <= d1;
			z0_s2 <= st0.zero;
			z1_s2 <= st1.zero;
		end
	end

	always_comb begin
		dot = DOT_W'(pxx_s2) + DOT_W'(pyy_s2) + DOT_W'(pzz_s2);
		thr = DOT_W'($signed({cos_thr_q, FRAC_W'(0)}));
		too_small = dot > thr;
		for (int i = 0; i < 3; i++) begin
			if (z0_s2) begin
				side_nx.alt[i] = z1_s2 ? '0 : d1_s2[i];
			end else begin
				side_nx.alt[i] = -d0_s2[i];
			end
		end
		side_nx.alt_or  = z0_s2 || z1_s2 || !too_small;
		side_nx.use_alt = z0_s2 || z1_s2 || too_small;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s3[0] <= pyz_s2 - pzy_s2;
			cr_s3[1] <= pzx_s2 - pxz_s2;
			cr_s3[2] <= pxy_s2 - pyx_s2;
			sm_s3    <= sm_s2;
			side_s3  <= side_nx;
			rp_s4[0] <= $signed(cr_s3[1]) * $signed(sm_s3[2]);
			rp_s4[1] <= $signed(cr_s3[2]) * $signed(sm_s3[1]);
			rp_s4[2] <= $signed(cr_s3[2]) * $signed(sm_s3[0]);
			rp_s4[3] <= $signed(cr_s3[0]) * $signed(sm_s3[2]);
			rp_s4[4] <= $signed(cr_s3[0]) * $signed(sm_s3[1]);
			rp_s4[5] <= $signed(cr_s3[1]) * $signed(sm_s3[0]);
			side_s4  <= side_s3;
			r_s5[0]  <= R_W'($signed(rp_s4[0])) - R_W'($signed(rp_s4[1]));
			r_s5[1]  <= R_W'($signed(rp_s4[2])) - R_W'($signed(rp_s4[3]));
			r_s5[2]  <= R_W'($signed(rp_s4[4])) - R_W'($signed(rp_s4[5]));
			side_s5  <= side_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= st0.vld;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	pjbn_unit #(.W(R_W), .SW(SIDE_W)) u_norm2 (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(v_s5), .vec(r_s5),
		.side_in(side_s5), .stat(st2), .uvec(u2), .side_out(side_u)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= st2.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en && st2.vld) begin
			if (side_u.use_alt || st2.zero) begin
				normal_x <= side_u.alt[0];
				normal_y <= side_u.alt[1];
				normal_z <= side_u.alt[2];
			end else begin
				normal_x <= u2[0];
				normal_y <= u2[1];
				normal_z <= u2[2];
			end
			oriented <= side_u.alt_or;
		end
	end

endmodule

### sv/pjbn_checker.sv
// Port-level checks of the polyline joint bisector normal block, bound to the top.
// Uses pjbn_pkg and polyline_joint_bisector_normal_assert.svh.
`timescale 1ns / 1ps

`include "polyline_joint_bisector_normal_assert.svh"

module pjbn_checker import pjbn_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic signed [Q_W-1:0] normal_x,
	input logic signed [Q_W-1:0] normal_y,
	input logic signed [Q_W-1:0] normal_z,
	input logic                  oriented
);

	`PJBN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && ($stable({normal_x, normal_y, normal_z, oriented})), "output word changed while stalled")
	`PJBN_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")
	`PJBN_ASSERT_NOW(a_range, out_valid, (normal_x >= -16384 && normal_x <= 16384 && normal_y >= -16384 && normal_y <= 16384 && normal_z >= -16384 && normal_z <= 16384), "normal out of range")
	`PJBN_ASSERT_NOW(a_flat_nonzero, out_valid && !oriented, (normal_x != 0 || normal_y != 0 || normal_z != 0), "unoriented word with zero normal")

endmodule

bind polyline_joint_bisector_normal pjbn_checker u_pjbn_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .normal_x(normal_x), .normal_y(normal_y),
	.normal_z(normal_z), .oriented(oriented)
);
